@@ design/push_pop_trace_structure_classifier_defines.svh @@
// Assertion macros used by the classifier RTL.
`ifndef PUSH_POP_TRACE_STRUCTURE_CLASSIFIER_DEFINES_SVH
`define PUSH_POP_TRACE_STRUCTURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every rising clock edge outside reset.
`define PPT_ASSERT(lbl, clk, rst, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (prop)) else $error(msg);

// Same-cycle implication.
`define PPT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) else $error(msg);

`else

`define PPT_ASSERT(lbl, clk, rst, prop, msg)
`define PPT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ design/ppt_pkg.sv @@
`default_nettype none

package ppt_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Verdict codes of a result beat
    localparam logic [2:0] VERDICT_NOT_SURE   = 3'd0;
    localparam logic [2:0] VERDICT_STACK      = 3'd1;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
    localparam logic [2:0] VERDICT_PRIORITY   = 3'd3;
    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd4;

    // Bit positions in the candidate live mask
    localparam int LIVE_STACK = 0;
    localparam int LIVE_QUEUE = 1;
    localparam int LIVE_PRIO  = 2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       could_be_stack;
        logic       could_be_queue;
        logic       could_be_priority;
        logic       overflowed;
    } result_t;

    // Command broadcast to every cell of the sorted row
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/ppt_ram.sv @@
`default_nettype none

module ppt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/ppt_cell.sv @@
`default_nettype none

module ppt_cell #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ppt_pkg::cell_ctrl_t          ctrl,
    input  wire logic signed [VALUE_BITS-1:0] push_value,
    input  wire logic                         left_keep,
    input  wire logic signed [VALUE_BITS-1:0] left_value,
    input  wire logic                         left_occ,
    input  wire logic signed [VALUE_BITS-1:0] right_value,
    input  wire logic                         right_occ,
    output logic                              keep,
    output logic signed [VALUE_BITS-1:0]      value,
    output logic                              occ
);

    import ppt_pkg::*;

    logic                         occ_reg;
    logic                         occ_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;

    // Row is sorted descending: a cell keeps its entry if it is occupied and not below the new value
    assign keep  = occ_reg && (value_reg >= push_value);
    assign value = value_reg;
    assign occ   = occ_reg;

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.push)
        begin
            if (!keep)
            begin
                // Take the new value at the insertion point, else shift down from the left
                if (left_keep)
                begin
                    value_next = push_value;
                    occ_next   = 1'b1;
                end
                else
                begin
                    value_next = left_value;
                    occ_next   = left_occ;
                end
            end
        end
        else if (ctrl.pop)
        begin
            // Advance toward the head
            value_next = right_value;
            occ_next   = right_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ design/push_pop_trace_structure_classifier.sv @@
// Channel  | Beat        | Handshake                        | Fields
// item     | item_t      | item_valid / item_stall (in)     | func, value
// result   | result_t    | result_valid / result_stall (out)| verdict, flags, overflowed
//
// An item first gets the registered read of the FIFO and stack RAMs at their current
// head pointers, then the check and update of all three candidates.
// The sorted cell row inserts or pops its head in that same update cycle.
// Reset zeroes pointers, counts and cell occupancy and sets every live flag; no clearing pass.
// item_stall is high while an item is in work or while a stalled result is held.
`default_nettype none
`include "push_pop_trace_structure_classifier_defines.svh"

module push_pop_trace_structure_classifier #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire ppt_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ppt_pkg::result_t      result
);

    import ppt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] CNT_FULL  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [SW-1:0] CAP_SUM   = SW'(CAPACITY);
    localparam logic [CAPACITY-1:0] OCC_ONE = CAPACITY'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    logic [1:0]                   func_reg;
    logic signed [VALUE_BITS-1:0] val_reg;
    logic signed [VALUE_BITS-1:0] item_val;

    logic [AW-1:0] fifo_head_reg;
    logic [AW-1:0] fifo_head_next;
    logic [CW-1:0] fifo_count_reg;
    logic [CW-1:0] fifo_count_next;
    logic [CW-1:0] stack_count_reg;
    logic [CW-1:0] stack_count_next;
    logic [2:0]    live_reg;
    logic [2:0]    live_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic          result_valid_reg;
    logic          result_valid_next;
    result_t       result_reg;
    result_t       result_next;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] fifo_tail;
    logic [CW-1:0] stack_top;
    logic          fifo_wr;
    logic          stack_wr;
    logic [VALUE_BITS-1:0] fifo_rd;
    logic [VALUE_BITS-1:0] stack_rd;

    cell_ctrl_t cell_ctrl;
    logic                         keep_w  [CAPACITY];
    logic signed [VALUE_BITS-1:0] val_w   [CAPACITY];
    logic [CAPACITY-1:0]          occ_w;

    logic accept;
    logic exec;

    // Handshake
    assign item_stall   = (state_reg != ST_IDLE) || (result_valid_reg && result_stall);
    assign accept       = item_valid && !item_stall;
    assign exec         = (state_reg == ST_EXEC);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Keep the low value bits, or sign-extend the 16-bit field
    generate
        if (VALUE_BITS <= 16)
        begin : g_narrow
            assign item_val = item.value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign item_val = {{(VALUE_BITS-16){item.value[15]}}, item.value};
        end
    endgenerate

    // RAM addresses follow the current pointers
    always_comb
    begin
        tail_sum = SW'(fifo_head_reg) + SW'(fifo_count_reg);
        if (tail_sum >= CAP_SUM)
        begin
            tail_sum = tail_sum - CAP_SUM;
        end
        fifo_tail = tail_sum[AW-1:0];
        stack_top = stack_count_reg - 1'b1;
    end

    ppt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_fifo_ram (
        .clk     (clk),
        .wr_en   (fifo_wr),
        .wr_addr (fifo_tail),
        .wr_data (val_reg),
        .rd_addr (fifo_head_reg),
        .rd_data (fifo_rd)
    );

    ppt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_wr),
        .wr_addr (stack_count_reg[AW-1:0]),
        .wr_data (val_reg),
        .rd_addr (stack_top[AW-1:0]),
        .rd_data (stack_rd)
    );

    // Sorted row for the priority candidate, maximum in cell zero
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                         lk;
            logic signed [VALUE_BITS-1:0] lv;
            logic                         lo;
            logic signed [VALUE_BITS-1:0] rv;
            logic                         ro;
            logic                         occ_o;
            if (i == 0)
            begin : g_first
                assign lk = 1'b1;
                assign lv = '0;
                assign lo = 1'b0;
            end
            else
            begin : g_inner_l
                assign lk = keep_w[i-1];
                assign lv = val_w[i-1];
                assign lo = occ_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign rv = '0;
                assign ro = 1'b0;
            end
            else
            begin : g_inner_r
                assign rv = val_w[i+1];
                assign ro = occ_w[i+1];
            end
            assign occ_w[i] = occ_o;
            ppt_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .push_value  (val_reg),
                .left_keep   (lk),
                .left_value  (lv),
                .left_occ    (lo),
                .right_value (rv),
                .right_occ   (ro),
                .keep        (keep_w[i]),
                .value       (val_w[i]),
                .occ         (occ_o)
            );
        end
    endgenerate

    function automatic logic [2:0] verdict_of(input logic [2:0] live);
        logic [2:0] v;
        case (live)
            3'b001:  v = VERDICT_STACK;
            3'b010:  v = VERDICT_QUEUE;
            3'b100:  v = VERDICT_PRIORITY;
            3'b000:  v = VERDICT_IMPOSSIBLE;
            default: v = VERDICT_NOT_SURE;
        endcase
        return v;
    endfunction

    // Check and update the candidates in the execute cycle
    always_comb
    begin
        state_next        = state_reg;
        fifo_head_next    = fifo_head_reg;
        fifo_count_next   = fifo_count_reg;
        stack_count_next  = stack_count_reg;
        live_next         = live_reg;
        ovf_next          = ovf_reg;
        fifo_wr           = 1'b0;
        stack_wr          = 1'b0;
        cell_ctrl         = '0;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (live_reg[LIVE_QUEUE])
                        begin
                            if (fifo_count_reg == CNT_FULL)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                fifo_wr         = 1'b1;
                                fifo_count_next = fifo_count_reg + 1'b1;
                            end
                        end
                        if (live_reg[LIVE_STACK])
                        begin
                            if (stack_count_reg == CNT_FULL)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                stack_wr         = 1'b1;
                                stack_count_next = stack_count_reg + 1'b1;
                            end
                        end
                        if (live_reg[LIVE_PRIO])
                        begin
                            if (occ_w[CAPACITY-1])
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                cell_ctrl.push = 1'b1;
                            end
                        end
                    end
                    FUNC_POP:
                    begin
                        if (live_reg[LIVE_QUEUE])
                        begin
                            if (fifo_count_reg == '0 || fifo_rd != val_reg)
                            begin
                                live_next[LIVE_QUEUE] = 1'b0;
                            end
                            else
                            begin
                                fifo_head_next  = (fifo_head_reg == LAST_ADDR) ? '0
                                                : fifo_head_reg + 1'b1;
                                fifo_count_next = fifo_count_reg - 1'b1;
                            end
                        end
                        if (live_reg[LIVE_STACK])
                        begin
                            if (stack_count_reg == '0 || stack_rd != val_reg)
                            begin
                                live_next[LIVE_STACK] = 1'b0;
                            end
                            else
                            begin
                                stack_count_next = stack_count_reg - 1'b1;
                            end
                        end
                        if (live_reg[LIVE_PRIO])
                        begin
                            if (!occ_w[0] || val_w[0] != val_reg)
                            begin
                                live_next[LIVE_PRIO] = 1'b0;
                            end
                            else
                            begin
                                cell_ctrl.pop = 1'b1;
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        fifo_head_next   = '0;
                        fifo_count_next  = '0;
                        stack_count_next = '0;
                        live_next        = '1;
                        ovf_next         = 1'b0;
                        cell_ctrl.clear  = 1'b1;
                    end
                    default:
                    begin
                        // Unused code: report the current verdict
                    end
                endcase
                result_valid_next             = 1'b1;
                result_next.verdict           = verdict_of(live_next);
                result_next.could_be_stack    = live_next[LIVE_STACK];
                result_next.could_be_queue    = live_next[LIVE_QUEUE];
                result_next.could_be_priority = live_next[LIVE_PRIO];
                result_next.overflowed        = ovf_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fifo_head_reg    <= '0;
            fifo_count_reg   <= '0;
            stack_count_reg  <= '0;
            live_reg         <= '1;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fifo_head_reg    <= fifo_head_next;
            fifo_count_reg   <= fifo_count_next;
            stack_count_reg  <= stack_count_next;
            live_reg         <= live_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the accepted beat and the pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= item.func;
            val_reg  <= item_val;
        end
        result_reg <= result_next;
    end

    `PPT_ASSERT(a_count_bound, clk, rst_n,
        (fifo_count_reg <= CNT_FULL) && (stack_count_reg <= CNT_FULL),
        "store count above capacity")

    `PPT_ASSERT(a_row_packed, clk, rst_n, (occ_w & (occ_w + OCC_ONE)) == '0,
        "priority row has a gap")

    `PPT_ASSERT_NEXT(a_dead_queue_frozen, clk, rst_n,
        !live_reg[LIVE_QUEUE] && !(exec && func_reg == FUNC_CLEAR),
        $stable(fifo_count_reg) && $stable(fifo_head_reg),
        "ruled-out queue was updated")

    `PPT_ASSERT_IMPL(a_result_from_exec, clk, rst_n, $rose(result_valid_reg),
        $past(state_reg == ST_EXEC), "result without an executed item")

endmodule

`default_nettype wire
